// ===== rtl/multi_antenna_complex_fir_channel_defines.svh =====
// ----------------------------------------------------------------------------
// multi_antenna_complex_fir_channel_defines
// assertion macros for the multi-antenna complex fir channel
// ----------------------------------------------------------------------------
`ifndef MULTI_ANTENNA_COMPLEX_FIR_CHANNEL_DEFINES_SVH
`define MULTI_ANTENNA_COMPLEX_FIR_CHANNEL_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk with async reset masked
`define MAFC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define MAFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MAFC_ASSERT_SAME(lbl, ante, cons, msg)
`define MAFC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/mafc_pkg.sv =====
// ----------------------------------------------------------------------------
// mafc_pkg
// shared types and codes of the multi-antenna complex fir channel
// ----------------------------------------------------------------------------
package mafc_pkg;

	// opcodes of an input item
	localparam logic [1:0] OP_SAMPLE  = 2'd0;
	localparam logic [1:0] OP_TAP     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_TX    = 2'd0;
	localparam logic [1:0] CFG_NUM_TAPS  = 2'd1;
	localparam logic [1:0] CFG_NOISE_ENA = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [1:0]         tx_antenna;
		logic [4:0]         tap_index;
		logic signed [15:0] value_re;
		logic signed [15:0] value_im;
		logic signed [15:0] noise_re;
		logic signed [15:0] noise_im;
	} item_t;

	typedef struct packed {
		logic signed [15:0] rx_re;
		logic signed [15:0] rx_im;
		logic               clipped;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic issue;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mac_go;
		logic last_issue;
		logic pipe_busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/mafc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mafc_ctrl
// sequencer for one time step: accept, run the mac sweep, drain, emit
// ----------------------------------------------------------------------------
module mafc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  mafc_pkg::dp_stat_t   stat,
	output mafc_pkg::ctrl_cmd_t  cmd
);
	import mafc_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d   = state_q;
		cmd.start = 1'b0;
		cmd.issue = 1'b0;
		cmd.emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid && stat.mac_go) begin
					cmd.start = 1'b1;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/mafc_dp.sv =====
// ----------------------------------------------------------------------------
// mafc_dp
// stores, history pointer, config registers, complex mac pipeline, rounding
// ----------------------------------------------------------------------------
module mafc_dp #(
	parameter int NUM_TX         = 4,
	parameter int MAX_TAPS       = 32,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mafc_pkg::item_t      item,
	input  logic                 accept,
	input  mafc_pkg::ctrl_cmd_t  cmd,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [5:0]           cfg_data,
	input  logic                 result_ready,
	output logic                 result_valid,
	output mafc_pkg::result_t    result,
	output mafc_pkg::dp_stat_t   stat
);
	import mafc_pkg::*;

	localparam int DEPTH = NUM_TX * MAX_TAPS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int SW    = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = 35 + $clog2(DEPTH + 1);

	localparam logic [2:0] NTX_CAP   = 3'((NUM_TX < 7) ? NUM_TX : 7);
	localparam logic [5:0] NTAPS_CAP = 6'((MAX_TAPS < 63) ? MAX_TAPS : 63);
	localparam logic [LW-1:0] SLOT_LAST = LW'(MAX_TAPS - 1);
	localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_TAPS);

	localparam int POS_BIAS_I = (COEF_FRAC_BITS > 0) ? (1 << (COEF_FRAC_BITS - 1)) : 0;
	localparam int NEG_BIAS_I = (1 << COEF_FRAC_BITS) - 1 - POS_BIAS_I;
	localparam logic signed [ACC_W-1:0] POS_BIAS = ACC_W'(POS_BIAS_I);
	localparam logic signed [ACC_W-1:0] NEG_BIAS = ACC_W'(NEG_BIAS_I);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32768);

	// configuration
	logic [2:0] cfg_ntx_q;
	logic [5:0] cfg_ntaps_q;
	logic       cfg_noise_q;
	logic [2:0] ntx_eff;
	logic [5:0] ntaps_eff;

	// time step bookkeeping
	logic [LW-1:0] hp_q;
	logic [SW-1:0] held_q;
	logic [LW-1:0] hp_adv;
	logic [SW-1:0] held_next;

	// mac sweep counters
	logic [2:0]    ant_q;
	logic [5:0]    tap_q;
	logic [LW-1:0] slot_q;
	logic [LW-1:0] slot0_q;
	logic [AW-1:0] base_q;

	// stores
	logic [31:0] hist_mem [DEPTH];
	logic [31:0] tap_mem  [DEPTH];
	logic [AW-1:0] in_row;
	logic [AW-1:0] hist_waddr;
	logic [AW-1:0] tap_waddr;
	logic [AW-1:0] hist_raddr;
	logic [AW-1:0] tap_raddr;
	logic          ant_active;
	logic          ant_last;
	logic          hist_we;
	logic          tap_we;

	// pipeline
	logic                 v_s1, v_s2, v_s3;
	logic [31:0]          hist_rd_s1;
	logic [31:0]          tap_rd_s1;
	logic signed [31:0]   p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [32:0]   sum_re_s3, sum_im_s3;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0] noise_re_w, noise_im_w;

	// rounding
	logic signed [ACC_W-1:0] rnd_re, rnd_im;
	logic signed [ACC_W-1:0] q_re, q_im;
	logic                    clip_re, clip_im;
	logic                    result_valid_q;
	result_t                 result_q;

	assign ntx_eff   = (cfg_ntx_q == 3'd0) ? 3'd1 :
	                   ((cfg_ntx_q > NTX_CAP) ? NTX_CAP : cfg_ntx_q);
	assign ntaps_eff = (cfg_ntaps_q == 6'd0) ? 6'd1 :
	                   ((cfg_ntaps_q > NTAPS_CAP) ? NTAPS_CAP : cfg_ntaps_q);

	assign hp_adv    = (hp_q == SLOT_LAST) ? '0 : hp_q + 1'b1;
	assign held_next = (int'(held_q) < MAX_TAPS) ? held_q + 1'b1 : held_q;

	assign ant_active = ({1'b0, item.tx_antenna} < ntx_eff);
	assign ant_last   = ({1'b0, item.tx_antenna} == (ntx_eff - 3'd1));

	assign in_row     = AW'(item.tx_antenna * MAX_TAPS);
	assign hist_waddr = in_row + AW'(hp_q);
	assign tap_waddr  = in_row + AW'(item.tap_index);
	assign hist_we    = accept && (item.opcode == OP_SAMPLE) && ant_active;
	assign tap_we     = accept && (item.opcode == OP_TAP) &&
	                    (int'(item.tx_antenna) < NUM_TX) && (int'(item.tap_index) < MAX_TAPS);

	assign hist_raddr = base_q + AW'(slot_q);
	assign tap_raddr  = base_q + AW'(tap_q);

	assign stat.mac_go     = (item.opcode == OP_SAMPLE) && ant_last &&
	                         (int'(held_next) >= int'(ntaps_eff));
	assign stat.last_issue = (tap_q == ntaps_eff - 6'd1) && (ant_q == ntx_eff - 3'd1);
	assign stat.pipe_busy  = v_s1 || v_s2 || v_s3;
	assign stat.out_free   = !result_valid_q || result_ready;

	assign noise_re_w = cfg_noise_q ? (ACC_W'(item.noise_re) <<< COEF_FRAC_BITS) : '0;
	assign noise_im_w = cfg_noise_q ? (ACC_W'(item.noise_im) <<< COEF_FRAC_BITS) : '0;

	// round half away from zero as one biased add and an arithmetic shift
	assign rnd_re  = acc_re_q + (acc_re_q[ACC_W-1] ? NEG_BIAS : POS_BIAS);
	assign rnd_im  = acc_im_q + (acc_im_q[ACC_W-1] ? NEG_BIAS : POS_BIAS);
	assign q_re    = rnd_re >>> COEF_FRAC_BITS;
	assign q_im    = rnd_im >>> COEF_FRAC_BITS;
	assign clip_re = (q_re > SAT_HI) || (q_re < SAT_LO);
	assign clip_im = (q_im > SAT_HI) || (q_im < SAT_LO);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// config registers and per-step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ntx_q   <= 3'd1;
			cfg_ntaps_q <= 6'd1;
			cfg_noise_q <= 1'b0;
			hp_q        <= '0;
			held_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NUM_TX:    cfg_ntx_q   <= cfg_data[2:0];
					CFG_NUM_TAPS:  cfg_ntaps_q <= cfg_data;
					CFG_NOISE_ENA: cfg_noise_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept && (item.opcode == OP_RESTART)) begin
				hp_q   <= '0;
				held_q <= '0;
			end else if (accept && (item.opcode == OP_SAMPLE) && ant_last) begin
				hp_q   <= hp_adv;
				held_q <= held_next;
			end
		end
	end

	// sweep counters: antenna outer, tap inner, slot walks back in time
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ant_q   <= '0;
			tap_q   <= '0;
			base_q  <= '0;
			slot_q  <= hp_q;
			slot0_q <= hp_q;
		end else if (cmd.issue) begin
			if (tap_q == ntaps_eff - 6'd1) begin
				tap_q  <= '0;
				ant_q  <= ant_q + 3'd1;
				base_q <= base_q + ROW_STEP;
				slot_q <= slot0_q;
			end else begin
				tap_q  <= tap_q + 6'd1;
				slot_q <= (slot_q == '0) ? SLOT_LAST : slot_q - 1'b1;
			end
		end
	end

	// stores, one write and one registered read each
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= {item.value_re, item.value_im};
		end
		if (cmd.issue) begin
			hist_rd_s1 <= hist_mem[hist_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_waddr] <= {item.value_re, item.value_im};
		end
		if (cmd.issue) begin
			tap_rd_s1 <= tap_mem[tap_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// complex mac pipeline
	always_ff @(posedge clk) begin
		p_rr_s2 <= $signed(hist_rd_s1[31:16]) * $signed(tap_rd_s1[31:16]);
		p_ii_s2 <= $signed(hist_rd_s1[15:0])  * $signed(tap_rd_s1[15:0]);
		p_ri_s2 <= $signed(hist_rd_s1[31:16]) * $signed(tap_rd_s1[15:0]);
		p_ir_s2 <= $signed(hist_rd_s1[15:0])  * $signed(tap_rd_s1[31:16]);
		sum_re_s3 <= 33'(p_rr_s2) - 33'(p_ii_s2);
		sum_im_s3 <= 33'(p_ri_s2) + 33'(p_ir_s2);
		if (cmd.start) begin
			acc_re_q <= noise_re_w;
			acc_im_q <= noise_im_w;
		end else if (v_s3) begin
			acc_re_q <= acc_re_q + ACC_W'(sum_re_s3);
			acc_im_q <= acc_im_q + ACC_W'(sum_im_s3);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.rx_re   <= clip_re ? (q_re[ACC_W-1] ? 16'sh8000 : 16'sh7fff) : q_re[15:0];
			result_q.rx_im   <= clip_im ? (q_im[ACC_W-1] ? 16'sh8000 : 16'sh7fff) : q_im[15:0];
			result_q.clipped <= clip_re || clip_im;
		end
	end

endmodule

// ===== rtl/multi_antenna_complex_fir_channel.sv =====
// ----------------------------------------------------------------------------
// multi_antenna_complex_fir_channel
// one receive antenna of a multi-antenna channel: complex fir per transmit
// antenna, summed, noise added, rounded and saturated to 16 bits
// ----------------------------------------------------------------------------
//
//  channel  handshake                 payload                 direction
//  item     item_valid / item_ready   item (item_t)           in
//  result   result_valid/result_ready result (result_t)       out
//  cfg      cfg_valid / cfg_ready     cfg_index, cfg_data     in
//
//  tap writes, restarts, ignored items and samples that do not close a
//  time step start no sweep. a sample that closes a time step with enough
//  history holds off the next item through the sweep, drain and emit:
//  the single complex mac reads one history/tap pair a cycle from the two stores.
//  reset clears pointer and step count and resets config; stores are not cleared.
//  the result sits in an output register; a finished sum waits for it to free.
//
`include "multi_antenna_complex_fir_channel_defines.svh"

module multi_antenna_complex_fir_channel #(
	parameter int NUM_TX         = 4,
	parameter int MAX_TAPS       = 32,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mafc_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output mafc_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [5:0]          cfg_data
);
	import mafc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      accept;
	logic      cfg_we;

	// config writes must be issued only while idle; the block does not enforce this and always takes them
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = item_valid && item_ready;

	// sequencer: idle, mac sweep, pipeline drain, emit
	mafc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// stores, bookkeeping, mac pipeline, rounding and output register
	mafc_dp #(
		.NUM_TX         (NUM_TX),
		.MAX_TAPS       (MAX_TAPS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.accept       (accept),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result),
		.stat         (stat)
	);

	// a sweep only starts on an accepted item
	`MAFC_ASSERT_SAME(a_start_on_accept, cmd.start, accept, "mac start without accepted item")
	// no item taken while the mac sweep runs
	`MAFC_ASSERT_SAME(a_no_accept_in_sweep, cmd.issue, !item_ready, "item taken during sweep")
	// the sum is only rounded once the pipeline is empty
	`MAFC_ASSERT_SAME(a_emit_after_drain, cmd.emit, !stat.pipe_busy, "emit with mac in flight")
	// input side closes right after a sweep starts
	`MAFC_ASSERT_NEXT(a_busy_after_start, cmd.start, !item_ready && cmd.issue, "sweep not running")

endmodule

// ===== sim/mafc_rx_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mafc_rx_scoreboard_pkg
// received-sample predictor and in-order checker for the channel testbench
// ----------------------------------------------------------------------------
package mafc_rx_scoreboard_pkg;

	import mafc_pkg::*;

	localparam int NUM_TX         = 4;
	localparam int MAX_TAPS       = 32;
	localparam int COEF_FRAC_BITS = 14;
	localparam int STORE_DEPTH    = NUM_TX * MAX_TAPS;

	class rx_scoreboard;

		logic signed [15:0] hist_re [STORE_DEPTH];
		logic signed [15:0] hist_im [STORE_DEPTH];
		bit                 hist_written [STORE_DEPTH];
		logic signed [15:0] coef_re [STORE_DEPTH];
		logic signed [15:0] coef_im [STORE_DEPTH];
		logic [4:0]         step_slot;
		int                 steps_held;
		logic [2:0]         tx_reg;
		logic [5:0]         taps_reg;
		bit                 noise_on;
		result_t            rx_due [$];
		int                 errors;
		int                 items_taken;

		function new();
			foreach (hist_written[i]) begin
				hist_written[i] = 0;
				hist_re[i] = '0;
				hist_im[i] = '0;
				coef_re[i] = '0;
				coef_im[i] = '0;
			end
			step_slot = '0;
			steps_held = 0;
			tx_reg = 3'd1;
			taps_reg = 6'd1;
			noise_on = 0;
			errors = 0;
			items_taken = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [5:0] data);
			case (idx)
				CFG_NUM_TX:    tx_reg = data[2:0];
				CFG_NUM_TAPS:  taps_reg = data;
				CFG_NOISE_ENA: noise_on = data[0];
				default: ;
			endcase
		endfunction

		function int active_tx();
			if (tx_reg == 0) return 1;
			if (tx_reg > NUM_TX) return NUM_TX;
			return int'(tx_reg);
		endfunction

		function int active_taps();
			if (taps_reg == 0) return 1;
			if (taps_reg > MAX_TAPS) return MAX_TAPS;
			return int'(taps_reg);
		endfunction

		function bit ignored(item_t it);
			if (it.opcode == OP_SAMPLE) return int'(it.tx_antenna) >= active_tx();
			return it.opcode != OP_TAP && it.opcode != OP_RESTART;
		endfunction

		// sample that closes a time step with enough history, so a sum is formed
		function bit closes_with_sum(item_t it);
			int held;
			if (it.opcode != OP_SAMPLE || int'(it.tx_antenna) != active_tx() - 1) return 0;
			held = steps_held < MAX_TAPS ? steps_held + 1 : steps_held;
			return held >= active_taps();
		endfunction

		// true if the sum of this item would touch a history entry never written
		function bit reads_blank(item_t it);
			int ntx;
			logic [4:0] slot;
			if (!closes_with_sum(it)) return 0;
			ntx = active_tx();
			for (int a = 0; a < ntx; a++) begin
				for (int l = 0; l < active_taps(); l++) begin
					slot = step_slot - 5'(l);
					if (!(a == ntx - 1 && l == 0) && !hist_written[a * MAX_TAPS + int'(slot)])
						return 1;
				end
			end
			return 0;
		endfunction

		// round half away from zero out of the coefficient fraction, then saturate
		function logic signed [15:0] round_sat(longint v, inout bit clip);
			longint mag;
			longint q;
			mag = v < 0 ? -v : v;
			q = (mag + (longint'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
			if (v < 0) begin
				if (q > 32768) begin
					clip = 1;
					return 16'sh8000;
				end
				return 16'(-q);
			end
			if (q > 32767) begin
				clip = 1;
				return 16'sh7fff;
			end
			return 16'(q);
		endfunction

		function void take_item(item_t it);
			int ntx;
			int ntaps;
			int k;
			logic [4:0] slot;
			longint acc_re;
			longint acc_im;
			longint xr;
			longint xi;
			longint cr;
			longint ci;
			bit clip;
			result_t r;
			items_taken++;
			case (it.opcode)
				OP_RESTART: begin
					step_slot = '0;
					steps_held = 0;
				end
				OP_TAP: begin
					k = int'(it.tx_antenna) * MAX_TAPS + int'(it.tap_index);
					coef_re[k] = it.value_re;
					coef_im[k] = it.value_im;
				end
				OP_SAMPLE: begin
					ntx = active_tx();
					ntaps = active_taps();
					if (int'(it.tx_antenna) >= ntx) return;
					k = int'(it.tx_antenna) * MAX_TAPS + int'(step_slot);
					hist_re[k] = it.value_re;
					hist_im[k] = it.value_im;
					hist_written[k] = 1;
					if (int'(it.tx_antenna) != ntx - 1) return;
					if (steps_held < MAX_TAPS) steps_held++;
					if (steps_held < ntaps) begin
						step_slot = step_slot + 5'd1;
						return;
					end
					acc_re = 0;
					acc_im = 0;
					for (int a = 0; a < ntx; a++) begin
						for (int l = 0; l < ntaps; l++) begin
							slot = step_slot - 5'(l);
							xr = hist_re[a * MAX_TAPS + int'(slot)];
							xi = hist_im[a * MAX_TAPS + int'(slot)];
							cr = coef_re[a * MAX_TAPS + l];
							ci = coef_im[a * MAX_TAPS + l];
							acc_re += xr * cr - xi * ci;
							acc_im += xr * ci + xi * cr;
						end
					end
					step_slot = step_slot + 5'd1;
					if (noise_on) begin
						acc_re += longint'(it.noise_re) * (longint'(1) << COEF_FRAC_BITS);
						acc_im += longint'(it.noise_im) * (longint'(1) << COEF_FRAC_BITS);
					end
					clip = 0;
					r.rx_re = round_sat(acc_re, clip);
					r.rx_im = round_sat(acc_im, clip);
					r.clipped = clip;
					rx_due.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_rx(result_t got);
			result_t want;
			if (rx_due.size() == 0) begin
				report($sformatf("rx item %0d %0d with none due", got.rx_re, got.rx_im));
				return;
			end
			want = rx_due.pop_front();
			if (got.rx_re !== want.rx_re)
				report($sformatf("rx_re got %0d want %0d", got.rx_re, want.rx_re));
			if (got.rx_im !== want.rx_im)
				report($sformatf("rx_im got %0d want %0d", got.rx_im, want.rx_im));
			if (got.clipped !== want.clipped)
				report($sformatf("clipped got %b want %b", got.clipped, want.clipped));
		endtask

		function int pending();
			return rx_due.size();
		endfunction

	endclass

endpackage

// ===== sim/multi_antenna_complex_fir_channel_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_antenna_complex_fir_channel_test
// loads every tap, runs a short directed set of samples, then random time
// steps under a range of antenna and tap counts; each received sample is
// checked field by field against an in-order prediction
// ----------------------------------------------------------------------------
module multi_antenna_complex_fir_channel_test;

	import mafc_pkg::*;
	import mafc_rx_scoreboard_pkg::*;

	// opcode the block has no use for
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
	localparam int HOLD_CYCLES = 400;   // long receiver hold-off
	localparam int SETTLE      = 20;    // idle cycles before a register write
	localparam int TAIL        = 60;    // quiet cycles after the last result

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [5:0] cfg_data;

	rx_scoreboard sb;
	bit           calm;         // no random idling on either side while set
	int           hold_at;      // items taken before the next receiver hold-off
	int           idle_cycles;
	int           next_ant;     // antenna expected next in the current time step

	// phase settings, raw register values so out-of-range codes are exercised
	int ph_tx    [12] = '{0, 4, 7, 2, 3, 1, 4, 2, 3, 1, 5, 6};
	int ph_taps  [12] = '{0, 32, 63, 3, 5, 1, 2, 1, 4, 8, 0, 7};
	int ph_noise [12] = '{0, 1, 1, 1, 0, 1, 0, 1, 1, 0, 1, 1};
	int ph_items [12] = '{40, 150, 30, 40, 40, 40, 40, 40, 40, 40, 30, 30};

	multi_antenna_complex_fir_channel uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog: any handshake restarts the count
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) ||
		    (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random back-pressure, plus long hold-offs so the block fills up
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sb.items_taken >= hold_at) begin
				result_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_at = hold_at < 600 ? 700 : 32'h3fff_ffff;
			end
			result_ready = calm || $urandom_range(99) >= 28;
			@(posedge clk);
			if (result_valid && result_ready) sb.check_rx(result);
		end
	end

	function automatic item_t mk(logic [1:0] op, logic [1:0] ant, logic [4:0] idx,
			logic signed [15:0] re, logic signed [15:0] im,
			logic signed [15:0] nre, logic signed [15:0] nim);
		item_t it;
		it.opcode = op;
		it.tx_antenna = ant;
		it.tap_index = idx;
		it.value_re = re;
		it.value_im = im;
		it.noise_re = nre;
		it.noise_im = nim;
		return it;
	endfunction

	// sample values: mostly scaled-down random, with the extremes mixed in
	function automatic logic signed [15:0] rand_sample();
		logic signed [15:0] v;
		int r;
		r = $urandom_range(99);
		v = 16'($urandom);
		if (r < 5) return 16'sh7fff;
		if (r < 10) return 16'sh8000;
		return v >>> $urandom_range(0, 5);
	endfunction

	// taps kept small most of the time so sums do not always saturate
	function automatic logic signed [15:0] rand_tap();
		logic signed [15:0] v;
		v = 16'($urandom);
		if ($urandom_range(99) < 15) return v;
		return v >>> $urandom_range(2, 6);
	endfunction

	function automatic item_t restart_item();
		return mk(OP_RESTART, 2'($urandom), 5'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endfunction

	// drive one item and hold it until the block takes it
	task automatic offer(item_t it);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 28) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		item_valid = 1'b1;
		item = it;
		do @(posedge clk); while (item_ready !== 1'b1);
		sb.take_item(it);
	endtask

	// a sum over history never written is avoided by restarting the history
	// first, and the item is dropped if the restart alone does not avoid it
	task automatic send(item_t it);
		if (sb.reads_blank(it)) offer(restart_item());
		if (!sb.reads_blank(it)) offer(it);
	endtask

	task automatic quiet_items();
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic drain();
		quiet_items();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [5:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// registers change only once the block has gone idle
	task automatic set_channel(int ntx, int ntaps, int noise);
		drain();
		repeat (SETTLE) @(negedge clk);
		write_reg(CFG_NUM_TX, 6'(ntx));
		write_reg(CFG_NUM_TAPS, 6'(ntaps));
		write_reg(CFG_NOISE_ENA, 6'(noise));
	endtask

	// random time steps: mostly antennas in order, some skips, tap writes, restarts,
	// unused opcodes and broken sequences; ignored items do not count toward the budget
	task automatic run_phase(int budget, int pause_at);
		int useful;
		int ntx;
		int r;
		item_t it;
		useful = 0;
		next_ant = 0;
		ntx = sb.active_tx();
		while (useful < budget) begin
			r = $urandom_range(99);
			if (r < 4) begin
				it = mk(OP_TAP, 2'($urandom), 5'($urandom), rand_tap(), rand_tap(),
					16'($urandom), 16'($urandom));
			end else if (r < 6) begin
				it = restart_item();
				next_ant = 0;
			end else if (r < 8) begin
				it = mk(OP_UNUSED, 2'($urandom), 5'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom), 16'($urandom));
			end else if (r < 11) begin
				// out of order, possibly an inactive antenna
				it = mk(OP_SAMPLE, 2'($urandom), 5'($urandom), rand_sample(), rand_sample(),
					16'($urandom), 16'($urandom));
			end else begin
				// occasionally skip an antenna so its older slot content is reused
				if (next_ant < ntx - 1 && $urandom_range(99) < 6) next_ant++;
				it = mk(OP_SAMPLE, 2'(next_ant), 5'($urandom), rand_sample(), rand_sample(),
					16'($urandom), 16'($urandom));
				next_ant = (next_ant + 1) % ntx;
			end
			if (!sb.ignored(it)) useful++;
			send(it);
			if (pause_at != 0 && useful == pause_at) begin
				// sender waits for every due result before going on
				drain();
				pause_at = 0;
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 0;
		hold_at = 300;
		next_ant = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every tap gets written before any sum can read it
		for (int a = 0; a < NUM_TX; a++) begin
			for (int l = 0; l < MAX_TAPS; l++) begin
				if (a == 0 && l == 0)
					send(mk(OP_TAP, 2'(a), 5'(l), 16'sh8000, 16'sh8000, '0, '0));
				else
					send(mk(OP_TAP, 2'(a), 5'(l), rand_tap(), rand_tap(),
						16'($urandom), 16'($urandom)));
			end
		end

		// directed, one antenna and one tap: tap of -2 - 2j drives saturation
		send(mk(OP_SAMPLE, 2'd0, 5'd0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000));
		send(mk(OP_SAMPLE, 2'd0, 5'd31, 16'sh8000, 16'sh8000, '0, '0));
		send(mk(OP_SAMPLE, 2'd0, 5'd0, 16'sh8000, 16'sh7fff, '0, '0));
		send(mk(OP_SAMPLE, 2'd0, 5'd0, 16'sh0000, 16'sh0000, '0, '0));
		// inactive antennas and the unused opcode give nothing
		send(mk(OP_SAMPLE, 2'd1, 5'd0, 16'sh1234, 16'sh4321, '0, '0));
		send(mk(OP_SAMPLE, 2'd3, 5'd31, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
		send(mk(OP_UNUSED, 2'd3, 5'd31, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
		send(mk(OP_RESTART, 2'd0, 5'd0, '0, '0, '0, '0));
		// tap of one half, to land exactly on rounding ties
		send(mk(OP_TAP, 2'd0, 5'd0, 16'sd8192, 16'sd0, '0, '0));
		send(mk(OP_TAP, 2'd3, 5'd31, 16'sh7fff, 16'sh8000, '0, '0));
		set_channel(1, 1, 1);
		send(mk(OP_SAMPLE, 2'd0, 5'd0, 16'sd1, -16'sd1, '0, '0));
		send(mk(OP_SAMPLE, 2'd0, 5'd0, 16'sd3, -16'sd3, '0, '0));
		// noise extremes alone, then pushed over the edge by the half
		send(mk(OP_SAMPLE, 2'd0, 5'd0, '0, '0, 16'sh7fff, 16'sh8000));
		send(mk(OP_SAMPLE, 2'd0, 5'd0, 16'sd1, 16'sd1, 16'sh7fff, 16'sh7fff));
		send(mk(OP_SAMPLE, 2'd0, 5'd0, -16'sd1, -16'sd1, 16'sh8000, 16'sh8000));

		for (int p = 0; p < 12; p++) begin
			set_channel(ph_tx[p], ph_taps[p], ph_noise[p]);
			calm = p == 5;
			run_phase(ph_items[p], p == 3 ? 30 : 0);
		end
		for (int p = 0; p < 2; p++) begin
			set_channel($urandom_range(0, 7), $urandom_range(0, 9), $urandom_range(0, 1));
			run_phase(40, 0);
		end
		calm = 0;

		drain();
		repeat (TAIL) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
